FILE: rtl/core/bid_pkg.sv
`default_nettype none

package bid_pkg;

  localparam int unsigned MAX_BATCH   = 1024;
  localparam int unsigned TABLE_SLOTS = 2048;

  localparam int unsigned KEY_W     = 64;
  localparam int unsigned UID_W     = 10;
  localparam int unsigned DCNT_W    = 11;
  localparam int unsigned IDX_W     = $clog2(TABLE_SLOTS);
  localparam int unsigned SID_W     = $clog2(MAX_BATCH);
  localparam int unsigned CNT_W     = $clog2(MAX_BATCH + 1);
  localparam int unsigned EPOCH_W   = 8;
  localparam int unsigned FOLD_N    = (KEY_W + IDX_W - 1) / IDX_W;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [UID_W-1:0]   uid_t;
  typedef logic [DCNT_W-1:0]  dcnt_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [SID_W-1:0]   sid_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [EPOCH_W-1:0] epoch_t;

  // one table slot; a slot is occupied only when its epoch matches the current one
  typedef struct packed {
    epoch_t epoch;
    sid_t   id;
    key_t   key;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE
  } state_e;

  typedef struct packed {
    logic accept;
    logic probe_next;
    logic resolve;
    logic clr_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic empty;
    logic scan_end;
    logic clr_last;
    logic epoch_wrap;
    logic out_free;
  } dp_stat_t;

  // xor fold of the key into a slot index
  function automatic idx_t home_slot(key_t key);
    idx_t h;
    h = '0;
    for (int i = 0; i < FOLD_N; i++) begin
      h = h ^ idx_t'(key >> (i * IDX_W));
    end
    if (int'(h) >= TABLE_SLOTS) begin
      h = h - idx_t'(TABLE_SLOTS);
    end
    return h;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bid_in_if.sv
`default_nettype none

interface bid_in_if;
  logic               valid;
  logic               ready;
  bid_pkg::key_t      key;
  logic               last_in_batch;

  modport source (output valid, output key, output last_in_batch, input ready);
  modport sink (input valid, input key, input last_in_batch, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bid_out_if.sv
`default_nettype none

interface bid_out_if;
  logic               valid;
  logic               ready;
  bid_pkg::uid_t      unique_id;
  logic               is_new;
  bid_pkg::dcnt_t     distinct_count;
  logic               overflow;
  logic               batch_done;

  modport source (output valid, output unique_id, output is_new, output distinct_count,
                  output overflow, output batch_done, input ready);
  modport sink (input valid, input unique_id, input is_new, input distinct_count,
                input overflow, input batch_done, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bid_ram.sv
`default_nettype none

module bid_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/bid_ctrl.sv
`default_nettype none

module bid_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire bid_pkg::dp_stat_t   stat_i,
  output      bid_pkg::ctrl_cmd_t  cmd_o
);

  bid_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bid_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      bid_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = bid_pkg::ST_IDLE;
        end
      end
      bid_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = bid_pkg::ST_PROBE;
        end
      end
      bid_pkg::ST_PROBE: begin
        if (stat_i.hit || stat_i.empty || stat_i.scan_end) begin
          // hold the read data until the output register is free
          if (stat_i.out_free) begin
            cmd_o.resolve = 1'b1;
            state_d = stat_i.epoch_wrap ? bid_pkg::ST_CLEAR : bid_pkg::ST_IDLE;
          end
        end else begin
          cmd_o.probe_next = 1'b1;
        end
      end
      default: begin
        state_d = bid_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/bid_dp.sv
`default_nettype none

module bid_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire bid_pkg::key_t       key_i,
  input  wire logic                last_i,
  input  wire bid_pkg::ctrl_cmd_t  cmd_i,
  output      bid_pkg::dp_stat_t   stat_o,
  input  wire logic                out_ready_i,
  output      logic                out_valid_o,
  output      bid_pkg::uid_t       unique_id_o,
  output      logic                is_new_o,
  output      bid_pkg::dcnt_t      distinct_count_o,
  output      logic                overflow_o,
  output      logic                batch_done_o
);

  bid_pkg::key_t   key_q;
  logic            last_q;
  bid_pkg::idx_t   pos_q, pos_d, pos_nx;
  bid_pkg::idx_t   prb_q, prb_d;
  bid_pkg::idx_t   clr_cnt_q, clr_cnt_d;
  bid_pkg::epoch_t epoch_q, epoch_d;
  bid_pkg::cnt_t   next_free_q, next_free_d, nf_inc;
  logic            out_valid_q, out_valid_d;
  bid_pkg::uid_t   uid_q;
  logic            is_new_q, ovf_q, done_q;
  bid_pkg::dcnt_t  dcnt_q;

  bid_pkg::slot_t  rd_slot, wr_slot;
  bid_pkg::idx_t   raddr, waddr;
  logic            re, we;
  logic            hit, empty, cap, insert;
  bid_pkg::sid_t   res_id;

  assign hit    = (rd_slot.epoch == epoch_q) && (rd_slot.key == key_q);
  assign empty  = (rd_slot.epoch != epoch_q);
  assign cap    = (next_free_q == bid_pkg::cnt_t'(bid_pkg::MAX_BATCH));
  assign insert = cmd_i.resolve && !hit && empty && !cap;
  assign pos_nx = (pos_q == bid_pkg::idx_t'(bid_pkg::TABLE_SLOTS - 1)) ? '0 : pos_q + 1'b1;

  assign stat_o.hit        = hit;
  assign stat_o.empty      = empty;
  assign stat_o.scan_end   = (prb_q == bid_pkg::idx_t'(bid_pkg::TABLE_SLOTS - 1));
  assign stat_o.clr_last   = (clr_cnt_q == bid_pkg::idx_t'(bid_pkg::TABLE_SLOTS - 1));
  assign stat_o.epoch_wrap = last_q && (epoch_q == '1);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // table access: probe reads, insert or clear writes
  assign re    = cmd_i.accept || cmd_i.probe_next;
  assign raddr = cmd_i.accept ? bid_pkg::home_slot(key_i) : pos_nx;
  assign we    = cmd_i.clr_step || insert;
  assign waddr = cmd_i.clr_step ? clr_cnt_q : pos_q;

  always_comb begin
    wr_slot = '0;
    if (!cmd_i.clr_step) begin
      wr_slot.epoch = epoch_q;
      wr_slot.id    = bid_pkg::sid_t'(next_free_q);
      wr_slot.key   = key_q;
    end
  end

  bid_ram #(
    .WIDTH (bid_pkg::SLOT_W),
    .DEPTH (bid_pkg::TABLE_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wr_slot),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_slot)
  );

  always_comb begin
    pos_d       = pos_q;
    prb_d       = prb_q;
    clr_cnt_d   = clr_cnt_q;
    epoch_d     = epoch_q;
    next_free_d = next_free_q;
    nf_inc      = insert ? next_free_q + 1'b1 : next_free_q;
    res_id      = hit ? rd_slot.id : (insert ? bid_pkg::sid_t'(next_free_q) : '0);
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    if (cmd_i.accept) begin
      pos_d = bid_pkg::home_slot(key_i);
      prb_d = '0;
    end
    if (cmd_i.probe_next) begin
      pos_d = pos_nx;
      prb_d = prb_q + 1'b1;
    end
    if (cmd_i.clr_step) begin
      next_free_d = '0;
      if (stat_o.clr_last) begin
        clr_cnt_d = '0;
        epoch_d   = bid_pkg::epoch_t'(1);
      end else begin
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
    end
    if (cmd_i.resolve) begin
      out_valid_d = 1'b1;
      next_free_d = nf_inc;
      // end of batch: a fresh epoch makes every slot read as empty
      if (last_q) begin
        next_free_d = '0;
        epoch_d     = epoch_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      epoch_q     <= bid_pkg::epoch_t'(1);
      next_free_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      clr_cnt_q   <= clr_cnt_d;
      epoch_q     <= epoch_d;
      next_free_q <= next_free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    prb_q <= prb_d;
    if (cmd_i.accept) begin
      key_q  <= key_i;
      last_q <= last_i;
    end
    if (cmd_i.resolve) begin
      uid_q    <= bid_pkg::uid_t'(res_id);
      is_new_q <= insert;
      ovf_q    <= !hit && !insert;
      dcnt_q   <= bid_pkg::dcnt_t'(nf_inc);
      done_q   <= last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign unique_id_o      = uid_q;
  assign is_new_o         = is_new_q;
  assign distinct_count_o = dcnt_q;
  assign overflow_o       = ovf_q;
  assign batch_done_o     = done_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(next_free_q) <= bid_pkg::MAX_BATCH)
    else $error("distinct count beyond capacity");

  a_resolve_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.resolve |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote an untaken transaction");

  a_resolve_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.resolve |=> out_valid_q)
    else $error("resolved item produced no result");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept || cmd_i.probe_next) |-> !(cmd_i.clr_step || insert))
    else $error("table read and write in the same cycle");

endmodule

`default_nettype wire

FILE: rtl/core/batch_index_dedup.sv
// a result is registered when the probe of its transaction resolves (linear probing, one
// table read per cycle until a hit, an empty slot or the end of the scan)
// a new item is accepted only after the last one has resolved; extra probes and an untaken
// result that holds the output register both delay the next acceptance
// reset: control clears at once, then a pass clearing all TABLE_SLOTS (2048) slots sweeps the
// slot table before the first item; the same pass runs after every 255th batch
`default_nettype none

module batch_index_dedup (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bid_in_if.sink    in_i,
  bid_out_if.source out_o
);

  bid_pkg::ctrl_cmd_t cmd;
  bid_pkg::dp_stat_t  stat;

  bid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bid_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .key_i            (in_i.key),
    .last_i           (in_i.last_in_batch),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .unique_id_o      (out_o.unique_id),
    .is_new_o         (out_o.is_new),
    .distinct_count_o (out_o.distinct_count),
    .overflow_o       (out_o.overflow),
    .batch_done_o     (out_o.batch_done)
  );

endmodule

`default_nettype wire
